// ----- rtl/mtnp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtnp_pkg
// shared types, character codes and pitch table for the melody text parser
// ----------------------------------------------------------------------------
package mtnp_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned FreqWidth   = 16;
   localparam int unsigned PeriodWidth = 20;
   localparam int unsigned MsWidth     = 16;
   localparam int unsigned ValWidth    = 16;
   localparam int unsigned OctWidth    = 8;
   localparam int unsigned DivWidth    = 32;

   localparam logic [CharWidth-1:0] ChComma = 8'h2C;
   localparam logic [CharWidth-1:0] ChColon = 8'h3A;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChHash  = 8'h23;
   localparam logic [CharWidth-1:0] ChDot   = 8'h2E;

   localparam logic [ValWidth-1:0] ResetLength = 16'd4;
   localparam logic [OctWidth-1:0] ResetOctave = 8'd6;
   localparam logic [ValWidth-1:0] ResetTempo  = 16'd63;
   localparam logic [DivWidth-1:0] MsNumerator  = 32'd240000;
   localparam logic [DivWidth-1:0] TickNumerator = 32'd1000000;

   typedef enum logic [1:0] {
      SEC_HEADER   = 2'd0,
      SEC_DEFAULTS = 2'd1,
      SEC_NOTES    = 2'd2
   } section_type;

   // header/defaults phases and note phases share one register
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_SKIP  = 3'd1,
      PH_LEAD  = 3'd2,
      PH_POS   = 3'd3,
      PH_NEG   = 3'd4,
      PH_SCAN  = 3'd5
   } phase_type;

   localparam logic [2:0] NpStart  = 3'd0;
   localparam logic [2:0] NpDigits = 3'd1;
   localparam logic [2:0] NpAcc    = 3'd2;
   localparam logic [2:0] NpOct    = 3'd3;
   localparam logic [2:0] NpDot    = 3'd4;
   localparam logic [2:0] NpDone   = 3'd5;

   typedef enum logic [1:0] {
      KEY_NONE = 2'd0,
      KEY_D    = 2'd1,
      KEY_O    = 2'd2,
      KEY_B    = 2'd3
   } key_type;

   typedef enum logic [1:0] {
      ACC_NONE  = 2'd0,
      ACC_SHARP = 2'd1,
      ACC_FLAT  = 2'd2
   } accidental_type;

   // controller -> datapath
   typedef struct packed {
      logic parse;      // apply one character
      logic load_div;   // start a division (numerator select below)
      logic div_ms;     // 1: ms division, 0: period division
      logic capture;    // latch note fields for result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic note_done;  // character closed a valid note
      logic div_busy;
   } status_type;

   function automatic logic [FreqWidth-1:0] pitch(input logic [1:0] row,
                                                   input logic [2:0] letter);
      logic [FreqWidth-1:0] f;
      f = '0;
      unique case (row)
         ACC_SHARP: begin
            unique case (letter)
               3'd0: f = 16'd276;
               3'd1: f = 16'd311;
               3'd2: f = 16'd348;
               3'd3: f = 16'd369;
               3'd4: f = 16'd415;
               3'd5: f = 16'd466;
               3'd6: f = 16'd522;
               default: f = '0;
            endcase
         end
         ACC_FLAT: begin
            unique case (letter)
               3'd0: f = 16'd246;
               3'd1: f = 16'd277;
               3'd2: f = 16'd310;
               3'd3: f = 16'd329;
               3'd4: f = 16'd369;
               3'd5: f = 16'd415;
               3'd6: f = 16'd465;
               default: f = '0;
            endcase
         end
         default: begin
            unique case (letter)
               3'd0: f = 16'd261;
               3'd1: f = 16'd294;
               3'd2: f = 16'd329;
               3'd3: f = 16'd349;
               3'd4: f = 16'd392;
               3'd5: f = 16'd440;
               3'd6: f = 16'd493;
               default: f = '0;
            endcase
         end
      endcase
      return f;
   endfunction

endpackage

// ----- rtl/mtnp_divider.sv -----
// ----------------------------------------------------------------------------
// mtnp_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mtnp_divider
   import mtnp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DivWidth-1:0] dividend,
   input  logic [DivWidth-1:0] divisor,
   output logic                busy,
   output logic [DivWidth-1:0] quotient
);

   localparam int unsigned CntWidth = $clog2(DivWidth + 1);

   logic [DivWidth-1:0] rem_ff, rem_in;
   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [DivWidth-1:0] dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [DivWidth:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[DivWidth-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CntWidth'(DivWidth);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DivWidth'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// ----- rtl/mtnp_datapath.sv -----
// ----------------------------------------------------------------------------
// mtnp_datapath
// character parsing state, note fields and result arithmetic
// ----------------------------------------------------------------------------
module mtnp_datapath
   import mtnp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [CharWidth-1:0]   char_code,
   output status_type             status,
   output logic                   is_rest,
   output logic [FreqWidth-1:0]   frequency_hz,
   output logic [PeriodWidth-1:0] period_ticks,
   output logic [MsWidth-1:0]     duration_ms,
   output logic                   divide_error,
   output logic                   last_note
);

   section_type          section_ff, section_in;
   logic [2:0]           phase_ff, phase_in;
   key_type              key_ff, key_in;
   logic [ValWidth-1:0]  acc_ff, acc_in;
   logic [ValWidth-1:0]  dlen_ff, dlen_in;
   logic [OctWidth-1:0]  doct_ff, doct_in;
   logic [ValWidth-1:0]  tempo_ff, tempo_in;
   logic [2:0]           letter_ff, letter_in;
   accidental_type       accd_ff, accd_in;
   logic [OctWidth-1:0]  noct_ff, noct_in;
   logic [ValWidth-1:0]  nlen_ff, nlen_in;
   logic                 ninv_ff, ninv_in;

   logic [FreqWidth-1:0] freq_ff;
   logic [DivWidth-1:0]  prod_ff;
   logic                 last_ff;

   logic                 is_dig, is_sp, ready_now, close;
   logic [3:0]           dig;
   logic [ValWidth-1:0]  acc10, val;
   logic [3:0]           lcode;

   assign is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
   assign is_sp  = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
   assign dig    = char_code[3:0];
   assign ready_now = (phase_ff >= NpAcc) && (phase_ff <= NpDone) && !ninv_ff;

   always_comb begin
      unique case (char_code)
         8'h63:   lcode = 4'd0;
         8'h64:   lcode = 4'd1;
         8'h65:   lcode = 4'd2;
         8'h66:   lcode = 4'd3;
         8'h67:   lcode = 4'd4;
         8'h61:   lcode = 4'd5;
         8'h62:   lcode = 4'd6;
         8'h70:   lcode = 4'd7;
         default: lcode = 4'd8;
      endcase
   end

   always_comb begin
      section_in = section_ff;
      phase_in   = phase_ff;
      key_in     = key_ff;
      acc_in     = acc_ff;
      dlen_in    = dlen_ff;
      doct_in    = doct_ff;
      tempo_in   = tempo_ff;
      letter_in  = letter_ff;
      accd_in    = accd_ff;
      noct_in    = noct_ff;
      nlen_in    = nlen_ff;
      ninv_in    = ninv_ff;
      close      = 1'b0;
      acc10      = ValWidth'(acc_ff * 10 + dig);
      val        = '0;
      if (cmd.parse) begin
         if (char_code == '0) begin
            close      = (section_ff == SEC_NOTES) && ready_now;
            section_in = SEC_HEADER;
            phase_in   = PH_START;
            key_in     = KEY_NONE;
            acc_in     = '0;
            dlen_in    = ResetLength;
            doct_in    = ResetOctave;
            tempo_in   = ResetTempo;
            letter_in  = '0;
            accd_in    = ACC_NONE;
            noct_in    = '0;
            nlen_in    = '0;
            ninv_in    = 1'b0;
         end else if (section_ff != SEC_NOTES) begin
            // a value store is wanted when val_store set
            logic val_store;
            logic scan;
            val_store = 1'b0;
            scan      = 1'b0;
            unique case (phase_ff)
               PH_START: begin
                  if (section_ff == SEC_HEADER && (char_code == 8'h6D ||
                      char_code == 8'h63 || char_code == 8'h73 || char_code == 8'h72)) begin
                     key_in   = KEY_NONE;
                     phase_in = PH_SKIP;
                  end else if (section_ff == SEC_DEFAULTS && (char_code == 8'h64 ||
                      char_code == 8'h6F || char_code == 8'h62)) begin
                     key_in   = (char_code == 8'h64) ? KEY_D :
                                (char_code == 8'h6F) ? KEY_O : KEY_B;
                     acc_in   = '0;
                     val      = '0;
                     val_store = 1'b1;
                     phase_in = PH_SKIP;
                  end else begin
                     scan = 1'b1;
                  end
               end
               PH_SKIP: phase_in = (key_ff == KEY_NONE) ? PH_SCAN : PH_LEAD;
               PH_LEAD: begin
                  if (is_sp) begin
                  end else if (char_code == ChPlus) begin
                     phase_in = PH_POS;
                  end else if (char_code == ChMinus) begin
                     phase_in = PH_NEG;
                  end else if (is_dig) begin
                     acc_in    = ValWidth'(dig);
                     val       = ValWidth'(dig);
                     val_store = 1'b1;
                     phase_in  = PH_POS;
                  end else begin
                     scan = 1'b1;
                  end
               end
               PH_POS, PH_NEG: begin
                  if (is_dig) begin
                     acc_in    = acc10;
                     val       = (phase_ff == PH_NEG) ? ValWidth'(-acc10) : acc10;
                     val_store = 1'b1;
                  end else begin
                     scan = 1'b1;
                  end
               end
               default: scan = 1'b1;
            endcase
            if (val_store) begin
               unique case (key_in)
                  KEY_D:   dlen_in  = val;
                  KEY_O:   doct_in  = val[OctWidth-1:0];
                  KEY_B:   tempo_in = val;
                  default: ;
               endcase
            end
            if (scan) begin
               if (char_code == ChComma) begin
                  phase_in = PH_START;
               end else if (char_code == ChColon) begin
                  key_in = KEY_NONE;
                  if (section_ff == SEC_HEADER) begin
                     section_in = SEC_DEFAULTS;
                     phase_in   = PH_START;
                  end else begin
                     section_in = SEC_NOTES;
                     phase_in   = NpStart;
                     letter_in  = '0;
                     accd_in    = ACC_NONE;
                     noct_in    = doct_ff;
                     nlen_in    = dlen_ff;
                     ninv_in    = 1'b0;
                  end
               end else begin
                  phase_in = PH_SCAN;
               end
            end
         end else if (char_code == ChComma) begin
            close     = ready_now;
            phase_in  = NpStart;
            letter_in = '0;
            accd_in   = ACC_NONE;
            noct_in   = doct_ff;
            nlen_in   = dlen_ff;
            ninv_in   = 1'b0;
         end else begin
            logic oct_chk;
            logic dot_chk;
            oct_chk = 1'b0;
            dot_chk = 1'b0;
            priority case (phase_ff)
               NpStart, NpDigits: begin
                  if (is_dig) begin
                     nlen_in  = ValWidth'(((phase_ff == NpStart) ? '0 : nlen_ff) * 10 + dig);
                     phase_in = NpDigits;
                  end else if (lcode[3]) begin
                     ninv_in  = 1'b1;
                     phase_in = NpDone;
                  end else begin
                     letter_in = lcode[2:0];
                     phase_in  = NpAcc;
                  end
               end
               NpAcc: begin
                  if (char_code == ChHash) begin
                     accd_in = ACC_SHARP; phase_in = NpOct;
                  end else if (char_code == 8'h62) begin
                     accd_in = ACC_FLAT; phase_in = NpOct;
                  end else begin
                     oct_chk = 1'b1;
                  end
               end
               NpOct:   oct_chk = 1'b1;
               NpDot:   dot_chk = 1'b1;
               default: ;
            endcase
            if (oct_chk) begin
               if (is_dig) begin
                  noct_in  = OctWidth'(dig);
                  phase_in = NpDot;
               end else begin
                  dot_chk = 1'b1;
               end
            end
            if (dot_chk) begin
               if (char_code == ChDot) begin
                  nlen_in = ValWidth'(({2'b0, nlen_ff} * 18'd3) >> 1);
               end
               phase_in = NpDone;
            end
         end
      end
   end

   // frequency of the note being closed
   logic [FreqWidth-1:0] base_f, shf_f;
   logic signed [OctWidth:0] sh;
   always_comb begin
      base_f = pitch(accd_ff, letter_ff);
      sh     = $signed({1'b0, noct_ff}) - 9'sd4;
      if (sh > 0) begin
         shf_f = (sh >= 16) ? '0 : FreqWidth'(base_f << sh[3:0]);
      end else if (sh < 0) begin
         shf_f = (sh <= -16) ? '0 : (base_f >> 4'(-sh));
      end else begin
         shf_f = base_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= SEC_HEADER;
         phase_ff   <= PH_START;
         key_ff     <= KEY_NONE;
         acc_ff     <= '0;
         dlen_ff    <= ResetLength;
         doct_ff    <= ResetOctave;
         tempo_ff   <= ResetTempo;
         letter_ff  <= '0;
         accd_ff    <= ACC_NONE;
         noct_ff    <= '0;
         nlen_ff    <= '0;
         ninv_ff    <= 1'b0;
      end else begin
         section_ff <= section_in;
         phase_ff   <= phase_in;
         key_ff     <= key_in;
         acc_ff     <= acc_in;
         dlen_ff    <= dlen_in;
         doct_ff    <= doct_in;
         tempo_ff   <= tempo_in;
         letter_ff  <= letter_in;
         accd_ff    <= accd_in;
         noct_ff    <= noct_in;
         nlen_ff    <= nlen_in;
         ninv_ff    <= ninv_in;
      end
      if (cmd.parse && close) begin
         freq_ff <= shf_f;
         prod_ff <= tempo_ff * nlen_ff;
         last_ff <= (char_code == '0);
      end
   end

   // shared divider
   logic                div_busy;
   logic [DivWidth-1:0] quo;
   mtnp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load_div),
      .dividend (cmd.div_ms ? MsNumerator : TickNumerator),
      .divisor  (cmd.div_ms ? prod_ff : DivWidth'(freq_ff)),
      .busy     (div_busy),
      .quotient (quo)
   );

   logic [PeriodWidth-1:0] per_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (cmd.div_ms) begin
            duration_ms  <= (prod_ff == '0) ? '0 : quo[MsWidth-1:0];
            divide_error <= (prod_ff == '0);
            frequency_hz <= freq_ff;
            is_rest      <= (freq_ff == '0);
            last_note    <= last_ff;
            period_ticks <= per_ff;
         end else begin
            per_ff <= (freq_ff == '0) ? '0 : quo[PeriodWidth-1:0];
         end
      end
   end

   assign status.note_done = cmd.parse && close;
   assign status.div_busy  = div_busy;

endmodule

// ----- rtl/mtnp_control.sv -----
// ----------------------------------------------------------------------------
// mtnp_control
// sequencer: parse a character, run both divisions, present the result
// ----------------------------------------------------------------------------
module mtnp_control
   import mtnp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PER_GO = 6'b000010,
      ST_PER    = 6'b000100,
      ST_MS_GO  = 6'b001000,
      ST_MS     = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // a new character may enter while the previous result waits
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.parse = req_valid;
            if (status.note_done) state_in = ST_PER_GO;
         end
         ST_PER_GO: begin
            cmd.load_div = 1'b1;
            state_in     = ST_PER;
         end
         ST_PER: if (!status.div_busy) begin
            cmd.capture = 1'b1;
            state_in    = ST_MS_GO;
         end
         ST_MS_GO: begin
            cmd.load_div = 1'b1;
            cmd.div_ms   = 1'b1;
            state_in     = ST_MS;
         end
         ST_MS: begin
            cmd.div_ms = 1'b1;
            if (!status.div_busy) state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_valid_ff || rsp_ready) begin
            cmd.div_ms   = 1'b1;
            cmd.capture  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_parse_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.parse |-> (state_ff == ST_IDLE)) else $error("parse outside idle");
   a_note_starts_div: assert property (@(posedge clock) disable iff (reset)
      status.note_done |=> (state_ff == ST_PER_GO)) else $error("note not divided");

endmodule

// ----- rtl/melody_text_note_parser.sv -----
// ----------------------------------------------------------------------------
// melody_text_note_parser
// parses melody text one character per item and emits one note item per note
// ----------------------------------------------------------------------------
// sequence: a note-closing character runs two divisions in turn, period then
//   ms, on one shared radix-2 divider before its result is presented
// throughput: one character per cycle between notes; no character is accepted
//   while a note is being divided, and input also stalls while a second finished
//   note waits on rsp_ready
// reset: synchronous; parser returns to the header section with defaults
//   length 4, octave 6, tempo 63; no result is pending
module melody_text_note_parser
   import mtnp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CharWidth-1:0]   req_char_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_rest,
   output logic [FreqWidth-1:0]   rsp_frequency_hz,
   output logic [PeriodWidth-1:0] rsp_period_ticks,
   output logic [MsWidth-1:0]     rsp_duration_ms,
   output logic                   rsp_divide_error,
   output logic                   rsp_last_note,
   output logic                   rsp_playing
);

   cmd_type    cmd;
   status_type status;

   // controller owns the handshakes and the divide sequence
   mtnp_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds the parse state, note fields and divider
   mtnp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .char_code    (req_char_code),
      .status       (status),
      .is_rest      (rsp_is_rest),
      .frequency_hz (rsp_frequency_hz),
      .period_ticks (rsp_period_ticks),
      .duration_ms  (rsp_duration_ms),
      .divide_error (rsp_divide_error),
      .last_note    (rsp_last_note)
   );

   // playing is simply the complement of the closing flag
   assign rsp_playing = !rsp_last_note;

endmodule

// ----- tb/tb_melody_text_note_parser.sv -----
// ----------------------------------------------------------------------------
// tb_melody_text_note_parser
// drives melody text through the parser, predicts every note item from an
// internal parser model and checks each result field; random idling on both
// channels across several phases
// ----------------------------------------------------------------------------
module tb_melody_text_note_parser;
   import mtnp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IdleLimit = 20000;

   // expected note item
   typedef struct packed {
      logic                   is_rest;
      logic [FreqWidth-1:0]   freq;
      logic [PeriodWidth-1:0] period;
      logic [MsWidth-1:0]     ms;
      logic                   div_err;
      logic                   last;
      logic                   playing;
   } note_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CharWidth-1:0]   req_char_code = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_is_rest;
   logic [FreqWidth-1:0]   rsp_frequency_hz;
   logic [PeriodWidth-1:0] rsp_period_ticks;
   logic [MsWidth-1:0]     rsp_duration_ms;
   logic                   rsp_divide_error;
   logic                   rsp_last_note;
   logic                   rsp_playing;

   melody_text_note_parser DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // parser model state
   // ---------------------------------------------------------------------
   section_type             m_sec;
   logic [2:0]              m_phase;
   key_type                 m_key;
   logic [ValWidth-1:0]     m_acc;
   logic [ValWidth-1:0]     m_def_len;
   logic [OctWidth-1:0]     m_def_oct;
   logic [ValWidth-1:0]     m_tempo;
   logic [2:0]              m_letter;
   accidental_type          m_accid;
   logic [OctWidth-1:0]     m_oct;
   logic [ValWidth-1:0]     m_len;
   logic                    m_bad;

   note_type notes_due[$];
   byte unsigned char_queue[$];
   int errors = 0;
   int sent = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_send = 1'b0;

   task automatic parser_clear();
      m_sec = SEC_HEADER; m_phase = PH_START; m_key = KEY_NONE; m_acc = '0;
      m_def_len = ResetLength; m_def_oct = ResetOctave; m_tempo = ResetTempo;
      m_letter = '0; m_accid = ACC_NONE; m_oct = '0; m_len = '0; m_bad = 1'b0;
   endtask

   task automatic note_open();
      m_phase = NpStart; m_letter = '0; m_accid = ACC_NONE;
      m_oct = m_def_oct; m_len = m_def_len; m_bad = 1'b0;
   endtask

   task automatic default_store(input logic [ValWidth-1:0] v);
      case (m_key)
         KEY_D: m_def_len = v;
         KEY_O: m_def_oct = v[7:0];
         KEY_B: m_tempo = v;
         default: ;
      endcase
   endtask

   function automatic bit is_dig(input byte unsigned c);
      return c >= "0" && c <= "9";
   endfunction

   // tone table, indexed by accidental and letter
   function automatic int unsigned tone_of(input accidental_type a, input logic [2:0] l);
      int unsigned nat[8] = '{261, 294, 329, 349, 392, 440, 493, 0};
      int unsigned shp[8] = '{276, 311, 348, 369, 415, 466, 522, 0};
      int unsigned flt[8] = '{246, 277, 310, 329, 369, 415, 465, 0};
      if (a == ACC_SHARP) return shp[l];
      if (a == ACC_FLAT) return flt[l];
      return nat[l];
   endfunction

   task automatic note_emit(input bit last);
      note_type n;
      int unsigned f;
      int sh;
      longint unsigned prod;
      f = tone_of(m_accid, m_letter);
      sh = int'(m_oct) - 4;
      if (sh > 0) f = (sh >= 16) ? 0 : ((f << sh) & 32'hFFFF);
      else if (sh < 0) f = f >> (-sh);
      prod = longint'(m_tempo) * longint'(m_len);
      n.is_rest = (f == 0);
      n.freq = f[15:0];
      n.period = (f != 0) ? 20'(1000000 / f) : '0;
      n.div_err = (prod == 0);
      n.ms = (prod == 0) ? '0 : 16'(240000 / prod);
      n.last = last;
      n.playing = !last;
      notes_due.push_back(n);
   endtask

   function automatic bit note_ok();
      return m_phase >= NpAcc && m_phase <= NpDone && !m_bad;
   endfunction

   task automatic field_end(input byte unsigned c);
      if (c == ",") m_phase = PH_START;
      else if (c == ":") begin
         m_key = KEY_NONE;
         if (m_sec == SEC_HEADER) begin
            m_sec = SEC_DEFAULTS; m_phase = PH_START;
         end else begin
            m_sec = SEC_NOTES; note_open();
         end
      end else m_phase = PH_SCAN;
   endtask

   // advance the model by one character
   task automatic parser_take(input byte unsigned c);
      int l;
      if (c == 0) begin
         if (m_sec == SEC_NOTES && note_ok()) note_emit(1'b1);
         parser_clear();
         return;
      end
      if (m_sec != SEC_NOTES) begin
         case (m_phase)
            PH_START: begin
               if (m_sec == SEC_HEADER && (c == "m" || c == "c" || c == "s" || c == "r")) begin
                  m_key = KEY_NONE; m_phase = PH_SKIP;
               end else if (m_sec == SEC_DEFAULTS && (c == "d" || c == "o" || c == "b")) begin
                  m_key = (c == "d") ? KEY_D : (c == "o") ? KEY_O : KEY_B;
                  m_acc = '0; default_store('0); m_phase = PH_SKIP;
               end else field_end(c);
            end
            PH_SKIP: m_phase = (m_key == KEY_NONE) ? PH_SCAN : PH_LEAD;
            PH_LEAD: begin
               if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) ;
               else if (c == ChPlus) m_phase = PH_POS;
               else if (c == ChMinus) m_phase = PH_NEG;
               else if (is_dig(c)) begin
                  m_acc = 16'(c - 8'h30); default_store(m_acc); m_phase = PH_POS;
               end else field_end(c);
            end
            PH_POS, PH_NEG: begin
               if (is_dig(c)) begin
                  m_acc = 16'(m_acc * 10 + (c - 8'h30));
                  default_store(m_phase == PH_NEG ? 16'(-m_acc) : m_acc);
               end else field_end(c);
            end
            default: field_end(c);
         endcase
         return;
      end
      if (c == ChComma) begin
         if (note_ok()) note_emit(1'b0);
         note_open();
         return;
      end
      // note fields; the fall-through chain is unrolled
      if (m_phase == NpStart || m_phase == NpDigits) begin
         if (is_dig(c)) begin
            m_len = 16'(((m_phase == NpStart) ? 0 : m_len) * 10 + (c - 8'h30));
            m_phase = NpDigits;
         end else begin
            case (c)
               "c": l = 0; "d": l = 1; "e": l = 2; "f": l = 3;
               "g": l = 4; "a": l = 5; "b": l = 6; "p": l = 7;
               default: l = -1;
            endcase
            if (l < 0) begin
               m_bad = 1'b1; m_phase = NpDone;
            end else begin
               m_letter = 3'(l); m_phase = NpAcc;
            end
         end
      end else if (m_phase == NpAcc && c == ChHash) begin
         m_accid = ACC_SHARP; m_phase = NpOct;
      end else if (m_phase == NpAcc && c == "b") begin
         m_accid = ACC_FLAT; m_phase = NpOct;
      end else if ((m_phase == NpAcc || m_phase == NpOct) && is_dig(c)) begin
         m_oct = 8'(c - 8'h30); m_phase = NpDot;
      end else if (m_phase >= NpAcc && m_phase <= NpDot) begin
         if (c == ChDot) m_len = 16'((32'(m_len) * 3) / 2);
         m_phase = NpDone;
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------
   task automatic push_text(input string s);
      foreach (s[i]) char_queue.push_back(s[i]);
   endtask

   function automatic string rand_num();
      string s;
      int n;
      s = "";
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
      return s;
   endfunction

   // a well-formed melody with random content, sometimes with noise
   task automatic push_melody(input int n_notes);
      string s;
      string letters;
      letters = "cdefgabp";
      s = ($urandom_range(0, 3) == 0) ? string'("mx,cz:") : string'("song:");
      if ($urandom_range(0, 3) != 0) s = {s, "d=", rand_num(), ","};
      if ($urandom_range(0, 3) != 0) s = {s, "o=", string'(byte'(8'h30 + $urandom_range(0, 9))), ","};
      if ($urandom_range(0, 3) != 0)
         s = {s, "b=", ($urandom_range(0, 5) == 0) ? string'("-") : string'(""),
              rand_num(), rand_num(), ","};
      s = {s.substr(0, s.len() - 2), ":"};
      for (int i = 0; i < n_notes; i++) begin
         if ($urandom_range(0, 9) == 0)
            s = {s, string'(byte'($urandom_range(1, 255)))};
         else begin
            s = {s, ($urandom_range(0, 2) == 0) ? rand_num() : string'("")};
            s = {s, string'(letters[$urandom_range(0, 7)])};
            case ($urandom_range(0, 3))
               0: s = {s, "#"};
               1: s = {s, "b"};
               default: ;
            endcase
            if ($urandom_range(0, 1)) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
            if ($urandom_range(0, 3) == 0) s = {s, "."};
         end
         if (i != n_notes - 1) s = {s, ","};
      end
      push_text(s);
      char_queue.push_back(8'h00);
   endtask

   // ---------------------------------------------------------------------
   // driver: one item per handshake from the pending queue
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         parser_take(req_char_code);
         sent++;
         if (char_queue.size() != 0 && !hold_send &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_char_code <= char_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && char_queue.size() != 0 && !hold_send &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_char_code <= char_queue.pop_front();
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // monitor: compare each note item with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      note_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (notes_due.size() == 0) begin
               report_mismatch("unexpected note item", 1, 0);
            end else begin
               e = notes_due.pop_front();
               if (rsp_is_rest !== e.is_rest) report_mismatch("is_rest", rsp_is_rest, e.is_rest);
               if (rsp_frequency_hz !== e.freq)
                  report_mismatch("frequency_hz", rsp_frequency_hz, e.freq);
               if (rsp_period_ticks !== e.period)
                  report_mismatch("period_ticks", rsp_period_ticks, e.period);
               if (rsp_duration_ms !== e.ms)
                  report_mismatch("duration_ms", rsp_duration_ms, e.ms);
               if (rsp_divide_error !== e.div_err)
                  report_mismatch("divide_error", rsp_divide_error, e.div_err);
               if (rsp_last_note !== e.last) report_mismatch("last_note", rsp_last_note, e.last);
               if (rsp_playing !== e.playing) report_mismatch("playing", rsp_playing, e.playing);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog on handshake-free cycles
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("melody_text_note_parser verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (char_queue.size() != 0 || req_valid || notes_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      parser_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, keys, signs, accidentals, octave extremes, dots
      push_text(":");
      push_text("c,:c,p,");
      char_queue.push_back(8'h00);
      push_text("mx:d=8,o=5,b=120:4c#,8db7.,p,b0,e9,x,,16a#.");
      char_queue.push_back(8'h00);
      push_text("rx:b= -0,d:c,2");
      char_queue.push_back(8'h00);
      push_text("s,:d=+65535,b=+2,o=255:c,99999g,d\tb=xyz:f");
      char_queue.push_back(8'h00);
      push_text("h:o=-1,b=1:a#,gb0.:zz");
      char_queue.push_back(8'hFF);
      char_queue.push_back(8'h00);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         while (sent < 210 * (ph + 1) + 100) begin
            if ($urandom_range(0, 4) == 0) begin
               // raw noise bytes, every bit value
               for (int i = 0; i < 12; i++) char_queue.push_back(8'($urandom_range(0, 255)));
               char_queue.push_back(8'h00);
            end else push_melody($urandom_range(1, 8));
            wait_drained();
         end
         // hold-off until every expected note item has come
         hold_send = 1'b1;
         wait_drained();
         repeat (100) @(posedge clock);
         hold_send = 1'b0;
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("melody_text_note_parser verification clean");
      else $display("melody_text_note_parser verification failed");
      $finish;
   end

endmodule
